>>> hw/rtl/wapf_pkg.sv
// Shared types and constants for the windowed absolute peak finder.
// Used by wapf_ctrl, wapf_dp and the top level; no dependencies.
package wapf_pkg;

    // Default sizes of the history and the sample word
    localparam int DEF_MAX_WINDOW  = 1024;
    localparam int DEF_MAX_BLOCK   = 1024;
    localparam int DEF_SAMPLE_BITS = 24;

    // Configuration register file
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_W-1:0] RST_WINDOW_SIZE    = 11'd64;
    localparam logic [CFG_W-1:0] RST_BLOCK_SIZE     = 11'd64;
    localparam logic [CFG_W-1:0] RST_OFFSET_SAMPLES = 11'd0;

    // Width of the reported peak position
    localparam int OUT_IDX_W = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_SIZE    = 2'd0,
        REG_BLOCK_SIZE     = 2'd1,
        REG_OFFSET_SAMPLES = 2'd2
    } wapf_cfg_reg_t;

    // Item kinds carried on the mode field
    localparam logic MODE_PUSH    = 1'b0;
    localparam logic MODE_ANALYZE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASE,
        ST_PTR,
        ST_SCAN,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_RESULT
    } wapf_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic push_write;
        logic calc_base;
        logic calc_ptr;
        logic scan_issue;
        logic load_result;
    } wapf_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic issue_last;
        logic out_free;
    } wapf_stat_t;

endpackage

>>> hw/rtl/wapf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wapf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/wapf_ctrl.sv
// Sequencing state machine of the windowed absolute peak finder.
// Depends on wapf_pkg for the state, command and status types.
module wapf_ctrl import wapf_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       mode,
    output logic       in_stall,
    input  wapf_stat_t st,
    output wapf_cmd_t  cmd
);

    wapf_state_t state_reg;
    wapf_state_t state_next;

    // Hold the current state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance through setup, scan, drain and result
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && mode == MODE_ANALYZE)
                begin
                    state_next = ST_BASE;
                end
            end
            ST_BASE:   state_next = ST_PTR;
            ST_PTR:    state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (st.issue_last)
                begin
                    state_next = ST_DRAIN1;
                end
            end
            ST_DRAIN1: state_next = ST_DRAIN2;
            ST_DRAIN2: state_next = ST_RESULT;
            ST_RESULT:
            begin
                if (st.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Drive commands for the current state
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall       = 1'b0;
                cmd.push_write = in_valid && (mode == MODE_PUSH);
            end
            ST_BASE:   cmd.calc_base  = 1'b1;
            ST_PTR:    cmd.calc_ptr   = 1'b1;
            ST_SCAN:   cmd.scan_issue = 1'b1;
            ST_DRAIN1: cmd = '0;
            ST_DRAIN2: cmd = '0;
            ST_RESULT: cmd.load_result = st.out_free;
            default:   cmd = '0;
        endcase
    end

    // Result loads only into a free output register
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |-> st.out_free)
        else $error("result loaded over a waiting result");

    // A scan leaves for the drain only after its last read
    a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && !st.issue_last) |=> state_reg == ST_SCAN)
        else $error("scan ended early");

    // Requests are taken only while idle
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BASE) |-> $past(state_reg == ST_IDLE))
        else $error("analyze started outside idle");

endmodule

>>> hw/rtl/wapf_dp.sv
// Datapath of the windowed absolute peak finder: configuration registers,
// history ring in wapf_ram, scan pipeline and output register. Uses wapf_pkg.
module wapf_dp import wapf_pkg::*; #(
    parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
    parameter int MAX_BLOCK   = DEF_MAX_BLOCK,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic [SAMPLE_BITS-1:0] sample_in,
    input  logic                   out_stall,
    input  wapf_cmd_t              cmd,
    output wapf_stat_t             st,
    output logic                   out_valid,
    output logic [SAMPLE_BITS-1:0] peak_magnitude,
    output logic [OUT_IDX_W-1:0]   peak_index
);

    localparam int HIST_DEPTH = MAX_WINDOW + MAX_BLOCK;
    localparam int AW         = $clog2(HIST_DEPTH);
    localparam int HIST_W     = $clog2(HIST_DEPTH + 1);
    localparam int PW         = $clog2(2 * HIST_DEPTH) + 1;
    localparam int CMP_W      = (CFG_W > HIST_W) ? CFG_W + 1 : HIST_W + 1;
    localparam int IDX_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WIDE_IDX_W = IDX_W + OUT_IDX_W;

    // Configuration registers
    logic [CFG_W-1:0] window_size_reg;
    logic [CFG_W-1:0] block_size_reg;
    logic [CFG_W-1:0] offset_samples_reg;

    // Clamped sizes, refreshed every cycle
    logic [CMP_W-1:0] win_c;
    logic [CMP_W-1:0] blk_c;
    logic [CMP_W-1:0] off_c;
    logic [CMP_W-1:0] ws_ext;
    logic [CMP_W-1:0] bs_ext;
    logic [CMP_W-1:0] os_ext;
    logic [IDX_W-1:0] win_last_reg;
    logic [HIST_W-1:0] len_reg;
    logic [HIST_W-1:0] off_reg;

    // Ring state
    logic [AW-1:0]     wp_reg;
    logic [HIST_W-1:0] fill_reg;
    logic [AW-1:0]     base_reg;
    logic [AW-1:0]     ptr_reg;
    logic [IDX_W-1:0]  cnt_reg;
    logic [PW-1:0]     base_sum;
    logic [PW-1:0]     ptr_sum;

    // Scan pipeline
    logic                   s1_valid_reg;
    logic                   s1_live_reg;
    logic [IDX_W-1:0]       s1_idx_reg;
    logic [SAMPLE_BITS-1:0] rdata;
    logic [SAMPLE_BITS-1:0] raw;
    logic [SAMPLE_BITS-1:0] mag;
    logic                   s2_valid_reg;
    logic [IDX_W-1:0]       s2_idx_reg;
    logic [SAMPLE_BITS-1:0] mag_reg;
    logic [SAMPLE_BITS-1:0] best_mag_reg;
    logic [IDX_W-1:0]       best_idx_reg;

    // Output register
    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] peak_magnitude_reg;
    logic [OUT_IDX_W-1:0]   peak_index_reg;
    logic [WIDE_IDX_W-1:0]  idx_wide;

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg    <= RST_WINDOW_SIZE;
            block_size_reg     <= RST_BLOCK_SIZE;
            offset_samples_reg <= RST_OFFSET_SAMPLES;
        end
        else if (cfg_valid)
        begin
            unique case (wapf_cfg_reg_t'(cfg_index))
                REG_WINDOW_SIZE:    window_size_reg    <= cfg_data;
                REG_BLOCK_SIZE:     block_size_reg     <= cfg_data;
                REG_OFFSET_SAMPLES: offset_samples_reg <= cfg_data;
                default:            window_size_reg    <= window_size_reg;
            endcase
        end
    end

    // Clamp sizes into range, offset at most the block
    always_comb
    begin
        ws_ext = CMP_W'(window_size_reg);
        bs_ext = CMP_W'(block_size_reg);
        os_ext = CMP_W'(offset_samples_reg);
        if (ws_ext == '0)
            win_c = CMP_W'(1);
        else if (ws_ext > CMP_W'(MAX_WINDOW))
            win_c = CMP_W'(MAX_WINDOW);
        else
            win_c = ws_ext;
        if (bs_ext == '0)
            blk_c = CMP_W'(1);
        else if (bs_ext > CMP_W'(MAX_BLOCK))
            blk_c = CMP_W'(MAX_BLOCK);
        else
            blk_c = bs_ext;
        off_c = (os_ext > blk_c) ? blk_c : os_ext;
    end

    always_ff @(posedge clk)
    begin
        win_last_reg <= IDX_W'(win_c - CMP_W'(1));
        len_reg      <= HIST_W'(win_c + blk_c);
        off_reg      <= HIST_W'(off_c);
    end

    // Append pushed samples, count filled slots up to the depth
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            fill_reg <= '0;
        end
        else if (cmd.push_write)
        begin
            wp_reg <= (wp_reg == AW'(HIST_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
            if (fill_reg != HIST_W'(HIST_DEPTH))
            begin
                fill_reg <= fill_reg + HIST_W'(1);
            end
        end
    end

    // Oldest slot, then first slot of the window, each wrapped once
    assign base_sum = PW'(wp_reg) + PW'(HIST_DEPTH) - PW'(len_reg);
    assign ptr_sum  = PW'(base_reg) + PW'(off_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.calc_base)
        begin
            base_reg <= (base_sum >= PW'(HIST_DEPTH)) ?
                        AW'(base_sum - PW'(HIST_DEPTH)) : AW'(base_sum);
        end
        if (cmd.calc_ptr)
        begin
            ptr_reg <= (ptr_sum >= PW'(HIST_DEPTH)) ?
                       AW'(ptr_sum - PW'(HIST_DEPTH)) : AW'(ptr_sum);
            cnt_reg <= '0;
        end
        else if (cmd.scan_issue)
        begin
            ptr_reg <= (ptr_reg == AW'(HIST_DEPTH - 1)) ? '0 : ptr_reg + AW'(1);
            cnt_reg <= cnt_reg + IDX_W'(1);
        end
    end

    wapf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (HIST_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (cmd.push_write),
        .waddr (wp_reg),
        .wdata (sample_in),
        .re    (cmd.scan_issue),
        .raddr (ptr_reg),
        .rdata (rdata)
    );

    // Track read requests alongside the RAM latency
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.scan_issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_live_reg <= HIST_W'(ptr_reg) < fill_reg;
        s1_idx_reg  <= cnt_reg;
        s2_idx_reg  <= s1_idx_reg;
        mag_reg     <= mag;
    end

    // Never-written slots read as zero; take the magnitude
    assign raw = s1_live_reg ? rdata : '0;
    assign mag = raw[SAMPLE_BITS-1] ? (~raw + SAMPLE_BITS'(1)) : raw;

    // Keep the first largest magnitude
    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && (s2_idx_reg == '0 || mag_reg > best_mag_reg))
        begin
            best_mag_reg <= mag_reg;
            best_idx_reg <= s2_idx_reg;
        end
    end

    // Output register: load on command, drop once taken
    assign idx_wide = WIDE_IDX_W'(best_idx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            peak_magnitude_reg <= best_mag_reg;
            peak_index_reg     <= idx_wide[OUT_IDX_W-1:0];
        end
    end

    assign out_valid      = out_valid_reg;
    assign peak_magnitude = peak_magnitude_reg;
    assign peak_index     = peak_index_reg;

    assign st.issue_last = (cnt_reg == win_last_reg);
    assign st.out_free   = !out_valid_reg || !out_stall;

    // Fill count never passes the ring depth
    a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= HIST_W'(HIST_DEPTH))
        else $error("fill count beyond ring depth");

    // Write pointer stays inside the ring
    a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg <= AW'(HIST_DEPTH - 1))
        else $error("write pointer outside ring");

    // No push lands while a scan is in flight
    a_push_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push_write |-> (!s1_valid_reg && !s2_valid_reg && !cmd.scan_issue))
        else $error("push during scan");

endmodule

>>> hw/rtl/windowed_abs_peak_finder.sv
// Windowed absolute peak finder. A push request (mode 0) writes one sample
// into a ring of MAX_WINDOW+MAX_BLOCK entries. An analyze request (mode 1)
// reads window_size samples, offset_samples past the oldest one, through the
// single read port of the history RAM, one sample a cycle, and returns the
// largest magnitude and its first position. Here window_size is the effective
// size: zero counts as one and larger values are clamped to MAX_WINDOW. After
// acceptance, the setup states compute the oldest slot and then the window
// start, the scan issues the reads, the drain states cover the RAM read and
// the magnitude register, the result state loads the output register, and
// the block returns to idle to take the next request. The load waits as long
// as an earlier result is still stalled in the output register. A finished
// result waits in the output register while new pushes are taken. Slots never
// pushed since reset read as zero through a fill count, so no clearing pass
// follows reset.
// Configuration is taken every cycle; write it only while the block is idle.
// Depends on wapf_pkg, wapf_ctrl, wapf_dp and wapf_ram.
module windowed_abs_peak_finder import wapf_pkg::*; #(
    parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
    parameter int MAX_BLOCK   = DEF_MAX_BLOCK,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   mode,
    input  logic [SAMPLE_BITS-1:0] sample_in,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [SAMPLE_BITS-1:0] peak_magnitude,
    output logic [OUT_IDX_W-1:0]   peak_index,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    wapf_cmd_t  cmd;
    wapf_stat_t st;

    assign cfg_ready = 1'b1;

    wapf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .mode     (mode),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    wapf_dp #(
        .MAX_WINDOW  (MAX_WINDOW),
        .MAX_BLOCK   (MAX_BLOCK),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .sample_in      (sample_in),
        .out_stall      (out_stall),
        .cmd            (cmd),
        .st             (st),
        .out_valid      (out_valid),
        .peak_magnitude (peak_magnitude),
        .peak_index     (peak_index)
    );

endmodule

>>> tb/wapf_peak_checker.sv
`timescale 1ns / 100ps
// Checker for windowed_abs_peak_finder: watches the request, result and
// configuration channels, keeps its own sample ring and flags mismatches.
// Depends on wapf_pkg.
module wapf_peak_checker import wapf_pkg::*; (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic                       mode,
    input  logic [DEF_SAMPLE_BITS-1:0] sample_in,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [DEF_SAMPLE_BITS-1:0] peak_magnitude,
    input  logic [OUT_IDX_W-1:0]       peak_index,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]           cfg_data,
    output int                         mismatches,
    output int                         outstanding
);

    localparam int SW   = DEF_SAMPLE_BITS;
    localparam int RING = DEF_MAX_WINDOW + DEF_MAX_BLOCK;

    typedef struct packed {
        logic [SW-1:0]        magnitude;
        logic [OUT_IDX_W-1:0] index;
    } peak_t;

    logic [SW-1:0]    ring_mem [RING];
    int unsigned      wr_slot;
    logic [CFG_W-1:0] window_reg;
    logic [CFG_W-1:0] block_reg;
    logic [CFG_W-1:0] offset_reg;
    peak_t            expected_peaks [$];
    int               fail_count;

    // Map a size register onto 1..hi
    function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
        if (v == 0)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    // Two's complement magnitude; the most negative sample maps to 2^(SW-1)
    function automatic logic [SW-1:0] magnitude_of(logic [SW-1:0] s);
        return s[SW-1] ? (~s + 1'b1) : s;
    endfunction

    // Scan the window and keep the first largest magnitude
    function automatic peak_t scan_window();
        int unsigned   win;
        int unsigned   blk;
        int unsigned   off;
        int unsigned   oldest;
        int unsigned   pos;
        logic [SW-1:0] m;
        peak_t         best;
        win    = clamp_size(window_reg, DEF_MAX_WINDOW);
        blk    = clamp_size(block_reg, DEF_MAX_BLOCK);
        off    = (offset_reg > blk) ? blk : offset_reg;
        oldest = (wr_slot + RING - win - blk) % RING;
        best   = '0;
        for (int unsigned i = 0; i < win; i++)
        begin
            pos = (oldest + off + i) % RING;
            m   = magnitude_of(ring_mem[pos]);
            if (i == 0 || m > best.magnitude)
            begin
                best.magnitude = m;
                best.index     = OUT_IDX_W'(i);
            end
        end
        return best;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        peak_t want;
        if (!rst_n)
        begin
            foreach (ring_mem[k])
                ring_mem[k] = '0;
            wr_slot    = 0;
            window_reg = RST_WINDOW_SIZE;
            block_reg  = RST_BLOCK_SIZE;
            offset_reg = RST_OFFSET_SAMPLES;
            expected_peaks.delete();
            fail_count = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            // Mirror register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_WINDOW_SIZE:    window_reg = cfg_data;
                    REG_BLOCK_SIZE:     block_reg  = cfg_data;
                    REG_OFFSET_SAMPLES: offset_reg = cfg_data;
                    default: ;
                endcase
            end

            // Store a pushed sample or predict the peak of an analyze request
            if (in_valid && !in_stall)
            begin
                if (mode == MODE_PUSH)
                begin
                    ring_mem[wr_slot] = sample_in;
                    wr_slot = (wr_slot + 1) % RING;
                end
                else
                    expected_peaks.push_back(scan_window());
            end

            // Compare each result with the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (expected_peaks.size() == 0)
                begin
                    $error("unexpected result: peak_magnitude %0d peak_index %0d",
                           peak_magnitude, peak_index);
                    fail_count++;
                end
                else
                begin
                    want = expected_peaks.pop_front();
                    if (peak_magnitude !== want.magnitude)
                    begin
                        $error("peak_magnitude: expected %0d, actual %0d",
                               want.magnitude, peak_magnitude);
                        fail_count++;
                    end
                    if (peak_index !== want.index)
                    begin
                        $error("peak_index: expected %0d, actual %0d",
                               want.index, peak_index);
                        fail_count++;
                    end
                end
            end

            mismatches  <= fail_count;
            outstanding <= expected_peaks.size();
        end
    end

endmodule

>>> tb/windowed_abs_peak_finder_tb.sv
`timescale 1ns / 100ps
// Testbench top for windowed_abs_peak_finder: drives push and analyze requests,
// register writes and result back-pressure; wapf_peak_checker does the checking.
// Depends on wapf_pkg, the RTL and wapf_peak_checker.
module windowed_abs_peak_finder_tb;
    import wapf_pkg::*;

    localparam int SW            = DEF_SAMPLE_BITS;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 150;
    localparam int SQUEEZE_PHASE = 3;
    localparam int WIDE_PHASE    = 7;
    localparam int LONG_HOLD     = 600;
    localparam int SETTLE        = 8;
    localparam int TAIL_CYCLES   = 1100;
    localparam int CYCLE_LIMIT   = 10000000;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 mode;
    logic [SW-1:0]        sample_in;
    logic                 out_valid;
    logic                 out_stall;
    logic [SW-1:0]        peak_magnitude;
    logic [OUT_IDX_W-1:0] peak_index;
    logic                 cfg_valid;
    logic                 cfg_ready;
    wapf_cfg_reg_t        cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int mismatches;
    int outstanding;
    int cycle_count  = 0;
    int tx_gap_pct   = 0;
    int rx_stall_pct = 0;
    bit rx_hold_req  = 1'b0;

    windowed_abs_peak_finder u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .sample_in      (sample_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .peak_magnitude (peak_magnitude),
        .peak_index     (peak_index),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    wapf_peak_checker u_peak_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .sample_in      (sample_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .peak_magnitude (peak_magnitude),
        .peak_index     (peak_index),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Mostly short idle stretches, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Mix of full-range values, tie-prone magnitudes, extremes and small values
    function automatic logic [SW-1:0] pick_sample();
        int            r;
        logic [SW-1:0] s;
        r = $urandom_range(0, 99);
        if (r < 45)
            s = SW'($urandom);
        else if (r < 65)
        begin
            s = SW'($urandom_range(0, 3) * 1024);
            if ($urandom_range(0, 1) == 1)
                s = -s;
        end
        else if (r < 75)
        begin
            case ($urandom_range(0, 3))
                0:       s = 24'h800000;
                1:       s = 24'h7FFFFF;
                2:       s = 24'h800001;
                default: s = '0;
            endcase
        end
        else
        begin
            s = SW'($urandom_range(0, 255));
            if ($urandom_range(0, 1) == 1)
                s = -s;
        end
        return s;
    endfunction

    // Result back-pressure; one long hold-off when requested
    initial
    begin : rx_pacing
        int held;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                out_stall <= 1'b1;
                held = 0;
                while (held < LONG_HOLD)
                begin
                    @(posedge clk);
                    held++;
                end
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
                repeat (idle_len()) @(posedge clk);
            end
        end
    end

    // Offer one request after an optional gap and hold it until accepted
    task automatic send_item(input logic m, input logic [SW-1:0] s);
        int gap;
        gap = ($urandom_range(0, 99) < tx_gap_pct) ? idle_len() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= m;
        sample_in <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drop valid and wait until every predicted peak has come back
    task automatic drain_peaks();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write one register, leaving valid up for a following write
    task automatic write_reg(input wapf_cfg_reg_t r, input logic [CFG_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] win, input logic [CFG_W-1:0] blk,
                              input logic [CFG_W-1:0] off);
        write_reg(REG_WINDOW_SIZE, win);
        write_reg(REG_BLOCK_SIZE, blk);
        write_reg(REG_OFFSET_SAMPLES, off);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int               burst;
        int               count;
        logic [CFG_W-1:0] win;
        logic [CFG_W-1:0] blk;
        logic [CFG_W-1:0] off;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        mode      = MODE_PUSH;
        sample_in = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_WINDOW_SIZE;
        cfg_data  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Reset sizes: empty history reads as zero, early pushes stay outside
        send_item(MODE_ANALYZE, '0);
        send_item(MODE_PUSH, 24'h7FFFFF);
        send_item(MODE_PUSH, 24'h800000);
        send_item(MODE_ANALYZE, '0);
        drain_peaks();

        // Window on the newest samples: most negative value, then a tie
        set_config(11'd4, 11'd2, 11'd2);
        send_item(MODE_PUSH, 24'h7FFFFF);
        send_item(MODE_PUSH, 24'h800000);
        send_item(MODE_PUSH, 24'h000005);
        send_item(MODE_PUSH, 24'hFFFFFB);
        send_item(MODE_ANALYZE, '0);
        send_item(MODE_PUSH, 24'h800001);
        send_item(MODE_PUSH, 24'h7FFFFF);
        send_item(MODE_ANALYZE, 24'hFFFFFF);
        drain_peaks();

        // Zero sizes act as one
        set_config(11'd0, 11'd0, 11'd0);
        send_item(MODE_PUSH, 24'h000007);
        send_item(MODE_PUSH, 24'hFFFFF7);
        send_item(MODE_ANALYZE, 24'h5A5A5A);
        drain_peaks();

        // Oversized registers clamp to the largest history
        set_config(11'd2047, 11'd2047, 11'd2047);
        send_item(MODE_ANALYZE, '0);
        drain_peaks();

        // Offset beyond block acts as the block size
        set_config(11'd3, 11'd5, 11'd9);
        send_item(MODE_PUSH, 24'h000001);
        send_item(MODE_PUSH, 24'h000002);
        send_item(MODE_PUSH, 24'h000003);
        send_item(MODE_ANALYZE, '0);
        drain_peaks();

        set_config(11'd1024, 11'd1, 11'd0);
        send_item(MODE_ANALYZE, '0);
        drain_peaks();

        set_config(11'd1, 11'd1024, 11'd0);
        send_item(MODE_ANALYZE, '0);
        drain_peaks();

        // Random phases: bursts of pushes closed by an analyze, plus noise
        for (int p = 0; p < PHASES; p++)
        begin
            if (p == WIDE_PHASE)
            begin
                win = CFG_W'($urandom_range(1000, 2047));
                blk = CFG_W'($urandom_range(900, 2047));
                off = CFG_W'($urandom_range(0, 2047));
            end
            else
            begin
                win = CFG_W'(($urandom_range(0, 99) < 10) ? 0 : $urandom_range(1, 40));
                blk = CFG_W'(($urandom_range(0, 99) < 10) ? 0 : $urandom_range(1, 40));
                off = CFG_W'($urandom_range(0, blk + 8));
            end
            set_config(win, blk, off);

            case (p % 3)
                0:       begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_gap_pct = 15; rx_stall_pct = 25; end
                default: begin tx_gap_pct = 40; rx_stall_pct = 60; end
            endcase
            if (p == SQUEEZE_PHASE)
            begin
                tx_gap_pct  = 0;
                rx_hold_req = 1'b1;
            end

            count = 0;
            while (count < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 99) < 80)
                begin
                    burst = (p == WIDE_PHASE) ? $urandom_range(10, 60) : $urandom_range(1, 20);
                    repeat (burst) send_item(MODE_PUSH, pick_sample());
                    send_item(MODE_ANALYZE, SW'($urandom));
                    count += burst + 1;
                end
                else
                begin
                    // Loose requests in random order
                    burst = $urandom_range(1, 6);
                    repeat (burst)
                    begin
                        if (p != WIDE_PHASE && $urandom_range(0, 3) == 0)
                            send_item(MODE_ANALYZE, SW'($urandom));
                        else
                            send_item(MODE_PUSH, pick_sample());
                    end
                    count += burst;
                end
            end
            drain_peaks();
        end

        // Catch any stray result
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/wapf_pkg.sv
hw/rtl/wapf_ram.sv
hw/rtl/wapf_ctrl.sv
hw/rtl/wapf_dp.sv
hw/rtl/windowed_abs_peak_finder.sv
tb/wapf_peak_checker.sv
tb/windowed_abs_peak_finder_tb.sv
